// ----- sv/tmsa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tmsa_pkg
// types, constants and helpers shared by the transient map slot allocator
// ----------------------------------------------------------------------------
package tmsa_pkg;

   // sizing
   localparam int SLOTS_PER_CPU  = 64;
   localparam int PHYS_ADDR_BITS = 36;
   localparam int PAGE_BYTES     = 4096;

   localparam int SLOT_BITS  = $clog2(SLOTS_PER_CPU);
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int PA_W       = 36;
   localparam int VA_W       = 32;
   localparam int ENTRY_W    = 9;
   localparam int CPU_W      = 3;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int VPAGE_W    = VA_W - PAGE_SHIFT;

   // physical address bits that must be zero
   localparam logic [PA_W-1:0] PA_RANGE_MASK =
      (PHYS_ADDR_BITS >= PA_W) ? '0 : ~((PA_W'(1) << PHYS_ADDR_BITS) - PA_W'(1));
   localparam logic [PA_W-1:0] PA_HIGH32_MASK = ~((PA_W'(1) << VA_W) - PA_W'(1));
   localparam logic [PA_W-1:0] PTE_FLAGS      = PA_W'(8'h63);

   typedef enum logic [CMD_W-1:0] {
      CMD_MAP        = 2'd0,
      CMD_UNMAP      = 2'd1,
      CMD_FLUSH_DONE = 2'd2,
      CMD_NONE       = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 2'd0,
      ST_NO_SLOT    = 2'd1,
      ST_BAD_PHYS   = 2'd2,
      ST_BAD_UNMAP  = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAE_MODE    = 2'd0,
      CSR_CPU_INDEX   = 2'd1,
      CSR_WINDOW_BASE = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [PA_W-1:0]  phys_addr;
      logic [VA_W-1:0]  virt_addr_in;
   } req_type;

   typedef struct packed {
      logic [VA_W-1:0]     virt_addr_out;
      logic                entry_write;
      logic [ENTRY_W-1:0]  entry_index;
      logic [PA_W-1:0]     entry_value;
      logic                flush_req;
      logic [VA_W-1:0]     flush_addr;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic execute;
   } dp_cmd_type;

   // lowest set bit: {found, index}
   function automatic logic [SLOT_BITS:0] lowest_set(input logic [SLOTS_PER_CPU-1:0] v);
      logic [SLOT_BITS:0] res;
      res = '0;
      for (int i = SLOTS_PER_CPU - 1; i >= 0; i--) begin
         if (v[i]) begin
            res = {1'b1, SLOT_BITS'(i)};
         end
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ----- sv/transient_map_slot_allocator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// transient_map_slot_allocator
// per-cpu allocator of temporary page mapping slots with deferred tlb flush
// ----------------------------------------------------------------------------
// flow: the accepting edge latches the item, the execute state registers the
//   result, which is then held until it is taken
// items: none is accepted while one executes; the execute state updates the
//   bitmaps, and the next item may be accepted as the result is handed off
// reset: synchronous, active high; all slots free, none released,
//   configuration cleared to zero; no clearing pass
// ----------------------------------------------------------------------------
module transient_map_slot_allocator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // item input
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire tmsa_pkg::req_type                 req_item,
   // result output
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output tmsa_pkg::rsp_type                      rsp_item,
   // configuration writes
   input  wire logic                              csr_wen,
   input  wire logic [tmsa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tmsa_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // sequencing commands from the controller
   tmsa_pkg::dp_cmd_type dp_cmd;

   // controller: idle -> execute -> hold result
   tmsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_cmd    (dp_cmd)
   );

   // datapath: free and released bitmaps, lowest slot search,
   // window address math and the result register
   tmsa_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .dp_cmd    (dp_cmd),
      .req_item  (req_item),
      .rsp_item  (rsp_item),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule
`default_nettype wire

// ----- sv/tmsa_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tmsa_ctrl
// sequencer: capture an item, execute it, hold the result until taken
// ----------------------------------------------------------------------------
module tmsa_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output tmsa_pkg::dp_cmd_type       dp_cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_RESP = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
         end
         S_EXEC: begin
            req_stall = 1'b1;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            // next item may enter as the result leaves
            req_stall = rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign accept = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (accept) state_in = S_EXEC;
            else if (!rsp_stall) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      dp_cmd.capture = accept;
      dp_cmd.execute = (state_ff == S_EXEC);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/tmsa_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tmsa_datapath
// slot bitmaps, configuration, item latch and result register
// ----------------------------------------------------------------------------
module tmsa_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire tmsa_pkg::dp_cmd_type                dp_cmd,
   input  wire tmsa_pkg::req_type                   req_item,
   output tmsa_pkg::rsp_type                        rsp_item,
   input  wire logic                                csr_wen,
   input  wire logic [tmsa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [tmsa_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int SB = tmsa_pkg::SLOT_BITS;
   localparam int NS = tmsa_pkg::SLOTS_PER_CPU;
   localparam int EW = tmsa_pkg::ENTRY_W;
   localparam int VW = tmsa_pkg::VA_W;
   localparam int PW = tmsa_pkg::VPAGE_W;

   logic                         pae_mode_ff;
   logic [tmsa_pkg::CPU_W-1:0]   cpu_index_ff;
   logic [VW-1:0]                window_base_ff;
   logic [NS-1:0]                free_ff, free_in;
   logic [NS-1:0]                released_ff, released_in;
   tmsa_pkg::req_type            req_ff;
   tmsa_pkg::rsp_type            rsp_ff, rsp_in;

   logic [SB:0]                  free_pick, rel_pick;
   logic [SB-1:0]                map_slot;
   logic                         bad_phys;
   logic [EW-1:0]                group_base;
   logic [EW-1:0]                map_entry;
   logic [VW-1:0]                map_va;
   logic [VW-1:0]                unmap_off;
   logic [PW-1:0]                unmap_page;
   logic [PW-1:0]                unmap_rel;
   logic                         unmap_in_group;
   logic [SB-1:0]                unmap_slot;
   logic                         unmap_busy;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pae_mode_ff    <= 1'b0;
         cpu_index_ff   <= '0;
         window_base_ff <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            tmsa_pkg::CSR_PAE_MODE:    pae_mode_ff    <= csr_wdata[0];
            tmsa_pkg::CSR_CPU_INDEX:   cpu_index_ff   <= csr_wdata[tmsa_pkg::CPU_W-1:0];
            tmsa_pkg::CSR_WINDOW_BASE: window_base_ff <= csr_wdata[VW-1:0];
            default: begin
            end
         endcase
      end
   end

   // shared address arithmetic
   assign group_base = EW'(cpu_index_ff) * EW'(NS);

   // map path
   assign bad_phys = (req_ff.phys_addr[tmsa_pkg::PAGE_SHIFT-1:0] != '0)
                  || ((req_ff.phys_addr & tmsa_pkg::PA_RANGE_MASK) != '0)
                  || (!pae_mode_ff && ((req_ff.phys_addr & tmsa_pkg::PA_HIGH32_MASK) != '0));
   assign free_pick = tmsa_pkg::lowest_set(free_ff);
   assign rel_pick  = tmsa_pkg::lowest_set(released_ff);
   assign map_slot  = free_pick[SB] ? free_pick[SB-1:0] : rel_pick[SB-1:0];
   assign map_entry = group_base + EW'(map_slot);
   assign map_va    = window_base_ff + (VW'(map_entry) << tmsa_pkg::PAGE_SHIFT);

   // unmap path
   assign unmap_off      = req_ff.virt_addr_in - window_base_ff;
   assign unmap_page     = unmap_off[VW-1:tmsa_pkg::PAGE_SHIFT];
   assign unmap_rel      = unmap_page - PW'(group_base);
   assign unmap_in_group = (unmap_page >= PW'(group_base)) && (unmap_rel < PW'(NS));
   assign unmap_slot     = unmap_rel[SB-1:0];
   assign unmap_busy     = free_ff[unmap_slot] || released_ff[unmap_slot];

   always_comb begin
      free_in     = free_ff;
      released_in = released_ff;
      rsp_in      = '0;
      case (tmsa_pkg::cmd_type'(req_ff.cmd))
         tmsa_pkg::CMD_MAP: begin
            if (bad_phys) begin
               rsp_in.status = tmsa_pkg::ST_BAD_PHYS;
            end else if (!free_pick[SB] && !rel_pick[SB]) begin
               rsp_in.status = tmsa_pkg::ST_NO_SLOT;
            end else begin
               free_in[map_slot] = 1'b0;
               if (!free_pick[SB]) begin
                  // reclaim a released slot, its old mapping may be cached
                  released_in[map_slot] = 1'b0;
                  rsp_in.flush_req      = 1'b1;
                  rsp_in.flush_addr     = map_va;
               end
               rsp_in.virt_addr_out = map_va;
               rsp_in.entry_write   = 1'b1;
               rsp_in.entry_index   = map_entry;
               rsp_in.entry_value   = req_ff.phys_addr | tmsa_pkg::PTE_FLAGS;
               rsp_in.status        = tmsa_pkg::ST_OK;
            end
         end
         tmsa_pkg::CMD_UNMAP: begin
            if (!unmap_in_group || unmap_busy) begin
               rsp_in.status = tmsa_pkg::ST_BAD_UNMAP;
            end else begin
               released_in[unmap_slot] = 1'b1;
               rsp_in.entry_write      = 1'b1;
               rsp_in.entry_index      = unmap_page[EW-1:0];
               rsp_in.status           = tmsa_pkg::ST_OK;
            end
         end
         tmsa_pkg::CMD_FLUSH_DONE: begin
            free_in     = free_ff | released_ff;
            released_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff     <= '1;
         released_ff <= '0;
      end else if (dp_cmd.execute) begin
         free_ff     <= free_in;
         released_ff <= released_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) req_ff <= req_item;
      if (dp_cmd.execute) rsp_ff <= rsp_in;
   end

   assign rsp_item = rsp_ff;

endmodule
`default_nettype wire

// ----- sv/tmsa_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tmsa_checker
// port level checks for the transient map slot allocator
// ----------------------------------------------------------------------------
module tmsa_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire tmsa_pkg::rsp_type   rsp_item
);

   logic req_acc;
   assign req_acc = req_valid && !req_stall;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed");

   // an accepted item's result follows its execute state, not earlier
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !rsp_valid ##1 rsp_valid)
      else $error("result timing wrong");

   // failed commands carry only a status
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status != tmsa_pkg::ST_OK) |->
         !rsp_item.entry_write && !rsp_item.flush_req && (rsp_item.virt_addr_out == '0))
      else $error("failed item has side effects");

   // a flush only comes with a map that reclaimed a slot
   a_flush_map: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.flush_req |->
         rsp_item.entry_write && (rsp_item.flush_addr == rsp_item.virt_addr_out))
      else $error("flush address mismatch");

endmodule

bind transient_map_slot_allocator tmsa_checker u_tmsa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);
`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the transient map slot allocator: random and
// directed map, unmap and flush-done items are driven under random idling,
// and each result is compared against a bitmap model kept in the bench
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tmsa_pkg::*;

   localparam int          WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
   localparam int          LONG_HOLD      = 80;    // receiver hold-off to back up the block
   localparam int          MAX_IDLE       = 12;
   localparam int          TAIL_CYCLES    = 8;
   localparam logic [35:0] PTE_BITS       = 36'h63; // valid, write, accessed, dirty

   // pending item plus the idle cycles the sender waits before offering it
   typedef struct {
      req_type     item;
      int unsigned gap;
   } queued_req;

   // dut ports; the inputs the bench drives are known from time zero
   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_item  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_item;
   logic                  csr_wen   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // bench copy of the block's configuration and slot bitmaps
   logic                  pae_sel      = 1'b0;
   logic [CPU_W-1:0]      cpu_sel      = '0;
   logic [VA_W-1:0]       window_va    = '0;
   logic [63:0]           free_map     = '1;
   logic [63:0]           released_map = '0;

   queued_req   send_queue[$];
   rsp_type     pending_outcomes[$];
   rsp_type     want_outcome;
   int unsigned items_sent     = 0;
   int unsigned items_accepted = 0;
   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles   = 0;
   bit          sender_eager   = 1'b0;
   int unsigned hold_requests  = 0;
   int unsigned holds_granted  = 0;
   int unsigned hold_left      = 0;
   int unsigned recv_wait      = 0;
   int unsigned eager_left     = 0;

   transient_map_slot_allocator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // slot model
   // ------------------------------------------------------------------------

   function automatic int first_one(logic [63:0] v);
      for (int i = 0; i < SLOTS_PER_CPU; i++) begin
         if (v[i]) begin
            return i;
         end
      end
      return -1;
   endfunction

   // window address of an entry, wraps at 32 bits
   function automatic logic [VA_W-1:0] entry_vaddr(int entry);
      return window_va + VA_W'(entry * PAGE_BYTES);
   endfunction

   // result of one item; updates the bitmaps as the block would
   function automatic rsp_type slot_outcome(req_type it);
      rsp_type          r;
      int               slot;
      int               entry;
      bit               reclaim;
      logic [VA_W-1:0]  offset;
      logic [VA_W-1:0]  va;
      r = '0;
      case (it.cmd)
         CMD_MAP: begin
            // address checks come before any slot is touched
            if (it.phys_addr % PAGE_BYTES != 0
                || (PHYS_ADDR_BITS < PA_W && (it.phys_addr >> PHYS_ADDR_BITS) != 0)
                || (!pae_sel && (it.phys_addr >> VA_W) != 0)) begin
               r.status = ST_BAD_PHYS;
            end else begin
               reclaim = 1'b0;
               slot    = first_one(free_map);
               if (slot < 0) begin
                  // nothing free: steal the lowest released slot
                  slot    = first_one(released_map);
                  reclaim = 1'b1;
               end
               if (slot < 0) begin
                  r.status = ST_NO_SLOT;
               end else begin
                  if (reclaim) begin
                     released_map[slot] = 1'b0;
                  end
                  free_map[slot]  = 1'b0;
                  entry           = slot + int'(cpu_sel) * SLOTS_PER_CPU;
                  va              = entry_vaddr(entry);
                  r.virt_addr_out = va;
                  r.entry_write   = 1'b1;
                  r.entry_index   = ENTRY_W'(entry);
                  r.entry_value   = it.phys_addr | PTE_BITS;
                  r.flush_req     = reclaim;
                  r.flush_addr    = reclaim ? va : '0;
                  r.status        = ST_OK;
               end
            end
         end
         CMD_UNMAP: begin
            offset = it.virt_addr_in - window_va;
            entry  = int'(offset / PAGE_BYTES);
            slot   = entry % SLOTS_PER_CPU;
            if (entry / SLOTS_PER_CPU != int'(cpu_sel)
                || free_map[slot] || released_map[slot]) begin
               r.status = ST_BAD_UNMAP;
            end else begin
               // entry cleared now, slot reusable only after a flush
               released_map[slot] = 1'b1;
               r.entry_write      = 1'b1;
               r.entry_index      = ENTRY_W'(entry);
               r.status           = ST_OK;
            end
         end
         CMD_FLUSH_DONE: begin
            free_map     = free_map | released_map;
            released_map = '0;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   function automatic req_type make_req(cmd_type cmd, logic [PA_W-1:0] pa,
                                        logic [VA_W-1:0] va);
      req_type it;
      it.cmd          = cmd;
      it.phys_addr    = pa;
      it.virt_addr_in = va;
      return it;
   endfunction

   // page that the current entry format accepts
   function automatic logic [PA_W-1:0] good_page();
      logic [PA_W-1:0] pa;
      pa        = {4'($urandom_range(0, 15)), 32'($urandom)};
      pa[11:0]  = '0;
      if (!pae_sel) begin
         pa[PA_W-1:VA_W] = '0;
      end
      return pa;
   endfunction

   // mostly good pages, some misaligned or with bits above 32 set
   function automatic logic [PA_W-1:0] pick_page();
      logic [PA_W-1:0] pa;
      pa = good_page();
      case ($urandom_range(0, 9))
         0: pa[11:0] = 12'($urandom_range(1, 4095));
         1: pa[PA_W-1:VA_W] = 4'($urandom_range(1, 15));
         default: begin
         end
      endcase
      return pa;
   endfunction

   // window address of a slot in this cpu's group, any byte in the page
   function automatic logic [VA_W-1:0] slot_vaddr(int slot, logic [11:0] byte_off);
      return entry_vaddr(int'(cpu_sel) * SLOTS_PER_CPU + slot) + VA_W'(byte_off);
   endfunction

   task automatic push_item(req_type it);
      queued_req q;
      q.item = it;
      q.gap  = sender_eager ? 0 : $urandom_range(0, MAX_IDLE);
      send_queue.push_back(q);
      items_sent++;
   endtask

   // sender stops until every item is in and every result is out
   task automatic drain();
      while (items_accepted != items_sent || pending_outcomes.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wen   <= 1'b0;
      case (idx)
         CSR_PAE_MODE:    pae_sel   = data[0];
         CSR_CPU_INDEX:   cpu_sel   = data[CPU_W-1:0];
         CSR_WINDOW_BASE: window_va = data;
         default: begin
         end
      endcase
   endtask

   // new setting once the block is idle; upper data bits are junk on purpose
   task automatic configure(bit pae, logic [CPU_W-1:0] cpu, logic [VA_W-1:0] base);
      drain();
      repeat (4) @(posedge clock);
      write_csr(CSR_PAE_MODE, {31'($urandom), pae});
      write_csr(CSR_CPU_INDEX, {29'($urandom), cpu});
      write_csr(CSR_WINDOW_BASE, base);
   endtask

   // fill every slot, run out, then reclaim released slots
   task automatic exhaust_and_reclaim();
      sender_eager = 1'b0;
      // sweep: every mapped slot becomes released, then free again
      for (int s = 0; s < SLOTS_PER_CPU; s++) begin
         push_item(make_req(CMD_UNMAP, '0, slot_vaddr(s, 12'($urandom))));
      end
      push_item(make_req(CMD_FLUSH_DONE, '0, '0));
      drain();
      // back-to-back maps against a stalled receiver
      sender_eager = 1'b1;
      hold_requests++;
      repeat (SLOTS_PER_CPU + 2) begin
         push_item(make_req(CMD_MAP, good_page(), 32'($urandom)));
      end
      sender_eager = 1'b0;
      repeat (6) begin
         push_item(make_req(CMD_UNMAP, 36'($urandom),
                            slot_vaddr($urandom_range(0, SLOTS_PER_CPU - 1),
                                       12'($urandom))));
      end
      // released slots get reclaimed with a flush request, then none left
      repeat (8) begin
         push_item(make_req(CMD_MAP, good_page(), 32'($urandom)));
      end
   endtask

   task automatic random_traffic(int unsigned budget);
      int unsigned start;
      int          top_slot;
      start = items_sent;
      while (items_sent - start < budget) begin
         sender_eager = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               repeat ($urandom_range(1, 8)) begin
                  push_item(make_req(CMD_MAP, pick_page(), 32'($urandom)));
               end
            end
            4, 5, 6: begin
               // low slots are the ones most likely mapped
               top_slot = $urandom_range(0, 1) ? 7 : SLOTS_PER_CPU - 1;
               repeat ($urandom_range(1, 6)) begin
                  if ($urandom_range(0, 9) == 0) begin
                     push_item(make_req(CMD_UNMAP, 36'($urandom), 32'($urandom)));
                  end else begin
                     push_item(make_req(CMD_UNMAP, 36'($urandom),
                                        slot_vaddr($urandom_range(0, top_slot),
                                                   12'($urandom))));
                  end
               end
            end
            7: begin
               push_item(make_req(CMD_FLUSH_DONE, 36'($urandom), 32'($urandom)));
            end
            default: begin
               // anything at all, the unused command too
               push_item(make_req(cmd_type'($urandom_range(0, 3)),
                                  {4'($urandom), 32'($urandom)}, 32'($urandom)));
            end
         endcase
      end
   endtask

   // ------------------------------------------------------------------------
   // driver: offers queued items, models each one as it is taken
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_outcomes.push_back(slot_outcome(req_item));
            items_accepted++;
         end
         // channel is free when nothing is offered or the offer was just taken
         if (!req_valid || !req_stall) begin
            if (send_queue.size() == 0) begin
               req_valid <= 1'b0;
            end else if (send_queue[0].gap != 0) begin
               send_queue[0].gap = send_queue[0].gap - 1;
               req_valid <= 1'b0;
            end else begin
               req_item  <= send_queue[0].item;
               req_valid <= 1'b1;
               send_queue.pop_front();
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // monitor: checks results, draws receiver stalls
   // ------------------------------------------------------------------------

   task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         // long hold-off requested by the stimulus
         if (holds_granted != hold_requests) begin
            hold_left = LONG_HOLD;
            holds_granted++;
         end else if (hold_left != 0) begin
            hold_left--;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               $display("%0t: result with nothing pending, expected none, got %p",
                        $time, rsp_item);
               mismatch_count++;
            end else begin
               want_outcome = pending_outcomes.pop_front();
               compare_field("virt_addr_out", 64'(want_outcome.virt_addr_out),
                             64'(rsp_item.virt_addr_out));
               compare_field("entry_write", 64'(want_outcome.entry_write),
                             64'(rsp_item.entry_write));
               compare_field("entry_index", 64'(want_outcome.entry_index),
                             64'(rsp_item.entry_index));
               compare_field("entry_value", 64'(want_outcome.entry_value),
                             64'(rsp_item.entry_value));
               compare_field("flush_req", 64'(want_outcome.flush_req),
                             64'(rsp_item.flush_req));
               compare_field("flush_addr", 64'(want_outcome.flush_addr),
                             64'(rsp_item.flush_addr));
               compare_field("status", 64'(want_outcome.status),
                             64'(rsp_item.status));
            end
            // stall before the next item, with stretches of none
            if (eager_left != 0) begin
               eager_left--;
               recv_wait = 0;
            end else begin
               recv_wait = $urandom_range(0, MAX_IDLE);
               if ($urandom_range(0, 15) == 0) begin
                  eager_left = $urandom_range(10, 30);
               end
            end
         end else if (recv_wait != 0) begin
            recv_wait--;
         end
         rsp_stall <= (recv_wait != 0) || (hold_left != 0);
      end
   end

   // ------------------------------------------------------------------------
   // watchdog: too long without any handshake
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
      end
      $display("end of test: mismatches");
      $finish;
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset-like setting: 32-bit entries, cpu 0, window at zero
      configure(1'b0, 3'd0, 32'h0);
      sender_eager = 1'b0;
      push_item(make_req(CMD_MAP, 36'h0_0000_0000, 32'h0));          // lowest page, slot 0
      push_item(make_req(CMD_MAP, 36'hF_FFFF_F000, 32'h0));          // too high for 32-bit
      push_item(make_req(CMD_MAP, 36'h0_0000_1001, 32'h0));          // misaligned
      push_item(make_req(CMD_MAP, 36'h0_FFFF_F000, 32'h0));          // top 32-bit page
      push_item(make_req(CMD_UNMAP, 36'h0, 32'h0000_0FFF));          // offset bits ignored
      push_item(make_req(CMD_UNMAP, 36'h0, 32'h0000_0000));          // already released
      push_item(make_req(CMD_UNMAP, 36'h0, 32'h0000_5000));          // still free
      push_item(make_req(CMD_UNMAP, 36'h0, 32'h0004_0000));          // other cpu's group
      push_item(make_req(CMD_UNMAP, 36'h0, 32'hFFFF_FFFF));          // far outside
      push_item(make_req(CMD_NONE, 36'hF_FFFF_FFFF, 32'hFFFF_FFFF)); // unused command
      push_item(make_req(CMD_FLUSH_DONE, 36'h0, 32'h0));
      push_item(make_req(CMD_UNMAP, 36'h0, 32'h0000_0000));          // free again after flush
      push_item(make_req(CMD_MAP, 36'h0_8000_0000, 32'h0));

      // pae entries, top cpu, window at the very top so addresses wrap
      configure(1'b1, 3'd7, 32'hFFFF_F000);
      push_item(make_req(CMD_MAP, 36'hF_FFFF_F000, 32'h0));          // full-width page
      push_item(make_req(CMD_MAP, 36'h8_0000_0FFF, 32'h0));          // misaligned
      push_item(make_req(CMD_UNMAP, 36'h0, slot_vaddr(2, 12'h000)));
      push_item(make_req(CMD_UNMAP, 36'h0, slot_vaddr(0, 12'hFFF)));
      exhaust_and_reclaim();
      random_traffic(60);

      configure(1'b0, 3'($urandom), {20'($urandom), 12'h000});
      random_traffic(110);

      // unaligned window base and a write to the spare register index
      configure(1'b1, 3'($urandom), 32'($urandom));
      write_csr(CSR_UNUSED, 32'($urandom));
      random_traffic(110);

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
